[rtl/core/seir_pkg.sv]
// ----------------------------------------------------------------------------
// seir_pkg
// Widths, codes and arithmetic helpers shared by the two-city SEIR step core.
// ----------------------------------------------------------------------------
package seir_pkg;

  localparam int VAL_W          = 34;
  localparam int IN_W           = 33;
  localparam int RATE_W         = 28;
  localparam int TRAVEL_W       = 25;
  localparam int DAY_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_ENT        = 8;
  localparam int ADDR_W         = 3;
  localparam int RATE_FRAC_BITS = 24;
  localparam int PROD_W         = VAL_W + RATE_W;
  localparam int SC_W           = PROD_W - RATE_FRAC_BITS + 1;
  localparam int NUM_SC         = 14;
  localparam int SC_IDX_W       = 4;
  localparam int CHUNK_W        = (SC_W - 1 + 1) / 2;
  localparam int DVD_W          = 72;
  localparam int DCNT_W         = 7;
  localparam int CAP_BIT        = 42;
  localparam int F_W            = CAP_BIT + 2;
  localparam int SUM_W          = F_W + 2;
  localparam int CNT_W          = 4;

  localparam logic [RATE_W-1:0]   RST_INFECT_A  = 28'd5447562;
  localparam logic [RATE_W-1:0]   RST_INFECT_B  = 28'd6710886;
  localparam logic [RATE_W-1:0]   RST_ONSET     = 28'd27950842;
  localparam logic [RATE_W-1:0]   RST_RECOVER   = 28'd2399142;
  localparam logic [TRAVEL_W-1:0] RST_TRAVEL    = 25'd16777;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INFECT_A  = 3'd0,
    REG_INFECT_B  = 3'd1,
    REG_ONSET_A   = 3'd2,
    REG_ONSET_B   = 3'd3,
    REG_RECOVER_A = 3'd4,
    REG_RECOVER_B = 3'd5,
    REG_TRAVEL    = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_PP,
    ST_DIV,
    ST_WB,
    ST_DONE
  } seir_state_t;

  function automatic logic [VAL_W-1:0] mag_val(input logic signed [VAL_W-1:0] v);
    mag_val = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

  function automatic logic signed [SC_W-1:0] round_rate(input logic [PROD_W-1:0] p,
                                                        input logic neg);
    logic [PROD_W-1:0] s;
    logic [SC_W-2:0]   q;
    s = p + (PROD_W'(1) << (RATE_FRAC_BITS - 1));
    q = s[PROD_W-1:RATE_FRAC_BITS];
    round_rate = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    lo = SUM_W'(-(64'sd1 <<< (VAL_W - 1)));
    if (v > hi) begin
      sat_val = hi[VAL_W-1:0];
    end else if (v < lo) begin
      sat_val = lo[VAL_W-1:0];
    end else begin
      sat_val = v[VAL_W-1:0];
    end
  endfunction

endpackage

[rtl/core/seir_if.sv]
// ----------------------------------------------------------------------------
// seir_if
// Valid/ready channels of the SEIR step core: input, result and config.
// ----------------------------------------------------------------------------
interface seir_in_if;
  import seir_pkg::*;
  logic            valid;
  logic            ready;
  logic            mode;
  logic [IN_W-1:0] start_susceptible_a;
  logic [IN_W-1:0] start_exposed_a;
  logic [IN_W-1:0] start_infected_a;
  logic [IN_W-1:0] start_recovered_a;
  logic [IN_W-1:0] start_susceptible_b;
  logic [IN_W-1:0] start_exposed_b;
  logic [IN_W-1:0] start_infected_b;
  logic [IN_W-1:0] start_recovered_b;
  modport source (output valid, mode, start_susceptible_a, start_exposed_a,
                  start_infected_a, start_recovered_a, start_susceptible_b,
                  start_exposed_b, start_infected_b, start_recovered_b,
                  input ready);
  modport sink (input valid, mode, start_susceptible_a, start_exposed_a,
                start_infected_a, start_recovered_a, start_susceptible_b,
                start_exposed_b, start_infected_b, start_recovered_b,
                output ready);
endinterface

interface seir_out_if;
  import seir_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DAY_W-1:0]        day_index;
  logic signed [VAL_W-1:0] susceptible_a;
  logic signed [VAL_W-1:0] exposed_a;
  logic signed [VAL_W-1:0] infected_a;
  logic signed [VAL_W-1:0] recovered_a;
  logic signed [VAL_W-1:0] susceptible_b;
  logic signed [VAL_W-1:0] exposed_b;
  logic signed [VAL_W-1:0] infected_b;
  logic signed [VAL_W-1:0] recovered_b;
  modport source (output valid, day_index, susceptible_a, exposed_a, infected_a,
                  recovered_a, susceptible_b, exposed_b, infected_b, recovered_b,
                  input ready);
  modport sink (input valid, day_index, susceptible_a, exposed_a, infected_a,
                recovered_a, susceptible_b, exposed_b, infected_b, recovered_b,
                output ready);
endinterface

interface seir_cfg_if;
  import seir_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/two_patch_seir_euler_step_top.sv]
// ----------------------------------------------------------------------------
// two_patch_seir_euler_step_top
// Loads the start counts or runs one forward Euler day of a two-city SEIR model over a compartment store.
// ----------------------------------------------------------------------------
// A load beat writes its start values into the store and passes them to the output register.
// A step beat reads the store, runs the rate multiplies and, per city, the partial products
// and a bit-serial divide, then writes the store back and loads the output register;
// a zero population skips its divide.
// One beat is in work at a time; the next is taken while a result waits.
// Synchronous reset restores the register defaults and reads the store as zero.
module two_patch_seir_euler_step_top import seir_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  seir_in_if.sink      in_ch,
  seir_out_if.source   out_ch,
  seir_cfg_if.sink     cfg_ch
);

  seir_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r;
  logic                    city_r;
  logic [RATE_W-1:0]       infect_r  [2];
  logic [RATE_W-1:0]       onset_r   [2];
  logic [RATE_W-1:0]       recover_r [2];
  logic [TRAVEL_W-1:0]     travel_r;
  logic [IN_W-1:0]         pop_r [2];
  logic [DAY_W-1:0]        day_r;
  logic signed [VAL_W-1:0] x_r   [NUM_ENT];
  logic signed [VAL_W-1:0] res_r [NUM_ENT];
  logic signed [SC_W-1:0]  sc_r  [NUM_SC];
  logic signed [F_W-1:0]   f_r   [2];
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_r;
  logic [DVD_W-1:0]        dvd_r;

  logic                    out_valid_r;
  logic [DAY_W-1:0]        out_day_r;
  logic signed [VAL_W-1:0] out_r [NUM_ENT];

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic signed [VAL_W-1:0] mem_rdata;

  logic                    div_start;
  logic                    div_done;
  logic [DVD_W-1:0]        div_q;

  logic [VAL_W-1:0]        mul_a;
  logic [RATE_W-1:0]       mul_b;
  logic                    mul_neg;
  logic [SC_W-2:0]         m_mag;
  logic [ADDR_W-1:0]       cidx;
  logic [ADDR_W-1:0]       wb_idx;
  logic signed [SUM_W-1:0] wb_sum;
  logic signed [VAL_W-1:0] wb_val;
  logic                    q_ovf;
  logic [CAP_BIT:0]        f_mag;
  logic [IN_W+1:0]         sum_a;
  logic [IN_W+1:0]         sum_b;
  logic                    in_acc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  seir_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (cnt_r[ADDR_W-1:0]),
    .rd_data (mem_rdata)
  );

  seir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (pop_r[city_r]),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infect_r[0]  <= RST_INFECT_A;
      infect_r[1]  <= RST_INFECT_B;
      onset_r[0]   <= RST_ONSET;
      onset_r[1]   <= RST_ONSET;
      recover_r[0] <= RST_RECOVER;
      recover_r[1] <= RST_RECOVER;
      travel_r     <= RST_TRAVEL;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_INFECT_A:  infect_r[0]  <= cfg_ch.data;
        REG_INFECT_B:  infect_r[1]  <= cfg_ch.data;
        REG_ONSET_A:   onset_r[0]   <= cfg_ch.data;
        REG_ONSET_B:   onset_r[1]   <= cfg_ch.data;
        REG_RECOVER_A: recover_r[0] <= cfg_ch.data;
        REG_RECOVER_B: recover_r[1] <= cfg_ch.data;
        REG_TRAVEL:    travel_r     <= cfg_ch.data[TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    cidx    = '0;
    m_mag   = sc_r[SC_IDX_W'(NUM_SC-2 + 32'(city_r))][SC_W-1]
            ? (SC_W-1)'(-sc_r[SC_IDX_W'(NUM_SC-2 + 32'(city_r))])
            : (SC_W-1)'(sc_r[SC_IDX_W'(NUM_SC-2 + 32'(city_r))]);
    if (state_r == ST_MUL) begin
      if (cnt_r < CNT_W'(8)) begin
        cidx  = cnt_r[ADDR_W-1:0];
        mul_b = RATE_W'(travel_r);
      end else if (cnt_r < CNT_W'(10)) begin
        cidx  = {cnt_r[0], 2'd1};
        mul_b = onset_r[cnt_r[0]];
      end else if (cnt_r < CNT_W'(12)) begin
        cidx  = {cnt_r[0], 2'd2};
        mul_b = recover_r[cnt_r[0]];
      end else begin
        cidx  = {cnt_r[0], 2'd0};
        mul_b = infect_r[cnt_r[0]];
      end
      mul_a   = mag_val(x_r[cidx]);
      mul_neg = x_r[cidx][VAL_W-1];
    end else if (state_r == ST_PP) begin
      cidx  = {city_r, 2'd2};
      mul_a = mag_val(x_r[cidx]);
      mul_b = (cnt_r == '0) ? RATE_W'(m_mag[CHUNK_W-1:0])
                            : RATE_W'(m_mag[SC_W-2:CHUNK_W]);
    end
  end

  assign q_ovf = (div_q[DVD_W-1:CAP_BIT+1] != '0) ||
                 (div_q[CAP_BIT] && (div_q[CAP_BIT-1:0] != '0));
  assign f_mag = q_ovf ? (CAP_BIT+1)'(1) << CAP_BIT : div_q[CAP_BIT:0];

  assign wb_idx = cnt_r[ADDR_W-1:0];
  always_comb begin
    logic signed [SUM_W-1:0] xv, own, oth, fv, se, gi;
    xv  = SUM_W'(x_r[wb_idx]);
    own = SUM_W'(sc_r[SC_IDX_W'(wb_idx)]);
    oth = SUM_W'(sc_r[SC_IDX_W'(wb_idx ^ 3'd4)]);
    fv  = SUM_W'(f_r[wb_idx[2]]);
    se  = SUM_W'(sc_r[SC_IDX_W'(8 + 32'(wb_idx[2]))]);
    gi  = SUM_W'(sc_r[SC_IDX_W'(10 + 32'(wb_idx[2]))]);
    unique case (wb_idx[1:0])
      2'd0:    wb_sum = xv - fv - own + oth;
      2'd1:    wb_sum = xv + fv - se - own + oth;
      2'd2:    wb_sum = xv + se - gi - own + oth;
      default: wb_sum = xv + gi - own + oth;
    endcase
  end
  assign wb_val = sat_val(wb_sum);

  assign mem_we    = (state_r == ST_LOAD) || (state_r == ST_WB);
  assign mem_waddr = cnt_r[ADDR_W-1:0];
  assign mem_wdata = (state_r == ST_LOAD) ? res_r[cnt_r[ADDR_W-1:0]] : wb_val;
  assign div_start = (state_r == ST_PP) && (cnt_r == CNT_W'(3)) && (pop_r[city_r] != '0);

  assign sum_a = (IN_W+2)'(in_ch.start_susceptible_a) + (IN_W+2)'(in_ch.start_exposed_a)
               + (IN_W+2)'(in_ch.start_infected_a) + (IN_W+2)'(in_ch.start_recovered_a);
  assign sum_b = (IN_W+2)'(in_ch.start_susceptible_b) + (IN_W+2)'(in_ch.start_exposed_b)
               + (IN_W+2)'(in_ch.start_infected_b) + (IN_W+2)'(in_ch.start_recovered_b);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_ch.mode ? ST_READ : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt_r == CNT_W'(NUM_ENT - 1)) state_nxt = ST_DONE;
      end
      ST_READ: begin
        if (cnt_r == CNT_W'(NUM_ENT)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(NUM_SC)) state_nxt = ST_PP;
      end
      ST_PP: begin
        if (cnt_r == CNT_W'(3)) begin
          if (div_start) begin
            state_nxt = ST_DIV;
          end else if (!city_r) begin
            state_nxt = ST_PP;
          end else begin
            state_nxt = ST_WB;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = city_r ? ST_WB : ST_PP;
      end
      ST_WB: begin
        if (cnt_r == CNT_W'(NUM_ENT - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      city_r  <= 1'b0;
      pop_r   <= '{default: '0};
      day_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_PP && cnt_r == CNT_W'(3) && !div_start) begin
        cnt_r  <= '0;
        city_r <= ~city_r;
      end else if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_DIV && div_done) begin
        city_r <= ~city_r;
      end
      if (in_acc) begin
        city_r <= 1'b0;
        if (!in_ch.mode) begin
          pop_r[0] <= (sum_a[IN_W+1:IN_W] != '0) ? '1 : sum_a[IN_W-1:0];
          pop_r[1] <= (sum_b[IN_W+1:IN_W] != '0) ? '1 : sum_b[IN_W-1:0];
          day_r    <= '0;
        end
      end
      if (state_r == ST_WB && cnt_r == CNT_W'(NUM_ENT - 1) && day_r != '1) begin
        day_r <= day_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !in_ch.mode) begin
      res_r[0] <= VAL_W'(in_ch.start_susceptible_a);
      res_r[1] <= VAL_W'(in_ch.start_exposed_a);
      res_r[2] <= VAL_W'(in_ch.start_infected_a);
      res_r[3] <= VAL_W'(in_ch.start_recovered_a);
      res_r[4] <= VAL_W'(in_ch.start_susceptible_b);
      res_r[5] <= VAL_W'(in_ch.start_exposed_b);
      res_r[6] <= VAL_W'(in_ch.start_infected_b);
      res_r[7] <= VAL_W'(in_ch.start_recovered_b);
    end
    if (state_r == ST_READ && cnt_r != '0) begin
      x_r[ADDR_W'(cnt_r - 1'b1)] <= mem_rdata;
    end
    prod_r <= mul_a * mul_b;
    neg_r  <= mul_neg;
    if (state_r == ST_MUL && cnt_r != '0) begin
      sc_r[SC_IDX_W'(cnt_r - 1'b1)] <= round_rate(prod_r, neg_r);
    end
    if (state_r == ST_PP) begin
      if (cnt_r == CNT_W'(1)) begin
        dvd_r <= DVD_W'(prod_r);
      end else if (cnt_r == CNT_W'(2)) begin
        dvd_r <= dvd_r + (DVD_W'(prod_r) << CHUNK_W);
      end else if (cnt_r == CNT_W'(3) && !div_start) begin
        f_r[city_r] <= '0;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      f_r[city_r] <= (m_mag == '0 || x_r[{city_r, 2'd2}] == '0) ? '0 :
                     ((sc_r[SC_IDX_W'(NUM_SC-2 + 32'(city_r))][SC_W-1]
                       != x_r[{city_r, 2'd2}][VAL_W-1])
                      ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag}));
    end
    if (state_r == ST_WB) begin
      res_r[wb_idx] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      out_r     <= res_r;
      out_day_r <= day_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.day_index     = out_day_r;
  assign out_ch.susceptible_a = out_r[0];
  assign out_ch.exposed_a     = out_r[1];
  assign out_ch.infected_a    = out_r[2];
  assign out_ch.recovered_a   = out_r[3];
  assign out_ch.susceptible_b = out_r[4];
  assign out_ch.exposed_b     = out_r[5];
  assign out_ch.infected_b    = out_r[6];
  assign out_ch.recovered_b   = out_r[7];

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> pop_r[city_r] != '0)
    else $error("divider started with a zero population");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat raised outside the done state");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_LOAD || state_r == ST_WB)
    else $error("store written outside a write phase");

  a_div_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");
`endif

endmodule

[rtl/core/seir_mem.sv]
// ----------------------------------------------------------------------------
// seir_mem
// Compartment store: eight entries, one write and one registered read port.
// ----------------------------------------------------------------------------
module seir_mem import seir_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] mem [NUM_ENT];
  logic [NUM_ENT-1:0]      vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

[rtl/core/seir_div.sv]
// ----------------------------------------------------------------------------
// seir_div
// Restoring divider, one quotient bit per cycle, for the infection term.
// ----------------------------------------------------------------------------
module seir_div import seir_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [IN_W-1:0]  divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  logic              run_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quot_r;
  logic [IN_W-1:0]   dsr_r;
  logic [IN_W-1:0]   rem_r;
  logic [IN_W:0]     sh;
  logic              ge;
  logic [IN_W:0]     diff;

  assign sh   = {rem_r, dvd_r[DVD_W-1]};
  assign ge   = sh >= {1'b0, dsr_r};
  assign diff = sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (run_r) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r  <= ge ? diff[IN_W-1:0] : sh[IN_W-1:0];
      quot_r <= {quot_r[DVD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[verif/seir_tb_if.sv]
// ----------------------------------------------------------------------------
// seir_tb_if
// Stand-in note: the channel interfaces come from the RTL interface file.
// This file holds the testbench's input beat record and the result record shared by driver and monitor.
// ----------------------------------------------------------------------------
package seir_tb_pkg;
  import seir_pkg::*;

  typedef struct packed {
    logic [DAY_W-1:0]        day;
    logic signed [VAL_W-1:0] sa, ea, ia, ra, sb, eb, ib, rb;
  } seir_result_t;

  typedef struct packed {
    logic            mode;
    logic [IN_W-1:0] sa, ea, ia, ra, sb, eb, ib, rb;
  } seir_beat_t;
endpackage

[verif/two_patch_seir_euler_step_top_test.sv]
// ----------------------------------------------------------------------------
// two_patch_seir_euler_step_top_test
// Drives load and step beats with random bursts and output stalls, predicts
// each day of the two-city SEIR model and checks every result beat.
// ----------------------------------------------------------------------------
module two_patch_seir_euler_step_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import seir_pkg::*;
  import seir_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  seir_in_if  in_ch ();
  seir_out_if out_ch ();
  seir_cfg_if cfg_ch ();

  two_patch_seir_euler_step_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [RATE_W-1:0] rate_reg [7];
  logic signed [63:0] pop_cnt [8];
  logic signed [63:0] city_pop [2];
  logic [DAY_W-1:0] day_cnt;

  seir_beat_t   pending_beats [$];
  seir_result_t expected_days [$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           hold_sender = 1'b0;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] rate_times(input logic [63:0] rate,
                                                     input logic signed [63:0] v);
    logic [63:0] q;
    q = (rate * mag64(v) + (64'd1 << 23)) >> 24;
    return v < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] clamp_val(input logic signed [63:0] v);
    if (v > 64'sd8589934591) return 64'sd8589934591;
    if (v < -64'sd8589934592) return -64'sd8589934592;
    return v;
  endfunction

  function automatic logic signed [63:0] infection_term(input logic [63:0] beta,
    input logic signed [63:0] s, input logic signed [63:0] inf,
    input logic signed [63:0] n);
    logic signed [63:0] m;
    logic [127:0] f;
    if (n <= 0) return 0;
    m = rate_times(beta, s);
    f = (128'(mag64(m)) * 128'(mag64(inf))) / 128'(n);
    if (f > (128'd1 << 42)) f = 128'd1 << 42;
    return ((m < 0) != (inf < 0)) ? -$signed(64'(f)) : $signed(64'(f));
  endfunction

  function automatic seir_result_t advance_day(input seir_beat_t b);
    seir_result_t r;
    logic signed [63:0] trv [8];
    logic signed [63:0] nxt [8];
    logic signed [63:0] f, se, gi;
    logic [63:0] sum;
    logic [IN_W-1:0] st [8];
    st = '{b.sa, b.ea, b.ia, b.ra, b.sb, b.eb, b.ib, b.rb};
    if (!b.mode) begin
      for (int c = 0; c < 2; c++) begin
        sum = 0;
        for (int i = 0; i < 4; i++) begin
          pop_cnt[c*4+i] = 64'(st[c*4+i]);
          sum += 64'(st[c*4+i]);
        end
        city_pop[c] = sum > 64'd8589934591 ? 64'sd8589934591 : $signed(sum);
      end
      day_cnt = 0;
    end else begin
      for (int i = 0; i < 8; i++) trv[i] = rate_times(rate_reg[REG_TRAVEL], pop_cnt[i]);
      for (int c = 0; c < 2; c++) begin
        f = infection_term(rate_reg[c], pop_cnt[c*4], pop_cnt[c*4+2], city_pop[c]);
        se = rate_times(rate_reg[2+c], pop_cnt[c*4+1]);
        gi = rate_times(rate_reg[4+c], pop_cnt[c*4+2]);
        nxt[c*4]   = clamp_val(pop_cnt[c*4] - f - trv[c*4] + trv[(1-c)*4]);
        nxt[c*4+1] = clamp_val(pop_cnt[c*4+1] + f - se - trv[c*4+1] + trv[(1-c)*4+1]);
        nxt[c*4+2] = clamp_val(pop_cnt[c*4+2] + se - gi - trv[c*4+2] + trv[(1-c)*4+2]);
        nxt[c*4+3] = clamp_val(pop_cnt[c*4+3] + gi - trv[c*4+3] + trv[(1-c)*4+3]);
      end
      pop_cnt = nxt;
      if (day_cnt != 16'hFFFF) day_cnt++;
    end
    r.day = day_cnt;
    r.sa = pop_cnt[0][VAL_W-1:0]; r.ea = pop_cnt[1][VAL_W-1:0];
    r.ia = pop_cnt[2][VAL_W-1:0]; r.ra = pop_cnt[3][VAL_W-1:0];
    r.sb = pop_cnt[4][VAL_W-1:0]; r.eb = pop_cnt[5][VAL_W-1:0];
    r.ib = pop_cnt[6][VAL_W-1:0]; r.rb = pop_cnt[7][VAL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_days.push_back(advance_day(pending_beats.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the beat until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0 && !hold_sender) begin
        seir_beat_t nb;
        nb = pending_beats[0];
        in_ch.valid <= 1'b1;
        {in_ch.mode, in_ch.start_susceptible_a, in_ch.start_exposed_a,
         in_ch.start_infected_a, in_ch.start_recovered_a, in_ch.start_susceptible_b,
         in_ch.start_exposed_b, in_ch.start_infected_b, in_ch.start_recovered_b} <= nb;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern and result checking.
  int stall_phase = 0;
  always @(posedge clk) begin
    seir_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ch.ready <= (stall_phase % 4000 < 1500) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.day_index, out_ch.susceptible_a, out_ch.exposed_a,
                out_ch.infected_a, out_ch.recovered_a, out_ch.susceptible_b,
                out_ch.exposed_b, out_ch.infected_b, out_ch.recovered_b};
        if (expected_days.size() == 0) begin
          report_mismatch("unexpected beat", 64'(got.day), 0);
        end else begin
          want = expected_days.pop_front();
          if (got.day !== want.day) report_mismatch("day_index", 64'(got.day), 64'(want.day));
          if (got.sa !== want.sa) report_mismatch("susceptible_a", 64'(got.sa), 64'(want.sa));
          if (got.ea !== want.ea) report_mismatch("exposed_a", 64'(got.ea), 64'(want.ea));
          if (got.ia !== want.ia) report_mismatch("infected_a", 64'(got.ia), 64'(want.ia));
          if (got.ra !== want.ra) report_mismatch("recovered_a", 64'(got.ra), 64'(want.ra));
          if (got.sb !== want.sb) report_mismatch("susceptible_b", 64'(got.sb), 64'(want.sb));
          if (got.eb !== want.eb) report_mismatch("exposed_b", 64'(got.eb), 64'(want.eb));
          if (got.ib !== want.ib) report_mismatch("infected_b", 64'(got.ib), 64'(want.ib));
          if (got.rb !== want.rb) report_mismatch("recovered_b", 64'(got.rb), 64'(want.rb));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] rand_start(input int kind);
    case (kind)
      0: return '0;
      1: return '1;
      2: return IN_W'($urandom_range(0, 32'h00FF_FFFF));
      default: return {$urandom(), 1'($urandom())};
    endcase
  endfunction

  function automatic seir_beat_t make_beat(input logic m, input int kind);
    seir_beat_t b;
    b.mode = m;
    b.sa = rand_start(kind); b.ea = rand_start(kind); b.ia = rand_start(kind);
    b.ra = rand_start(kind); b.sb = rand_start(kind); b.eb = rand_start(kind);
    b.ib = rand_start(kind); b.rb = rand_start(kind);
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_days.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [RATE_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    rate_reg[idx] = (idx == REG_TRAVEL) ? RATE_W'(val[TRAVEL_W-1:0]) : val;
    @(posedge clk);
  endtask

  task automatic config_phase(input int setting);
    for (int i = 0; i < 7; i++) begin
      logic [RATE_W-1:0] v;
      case (setting)
        0: v = '0;
        1: v = '1;
        2: v = (i == REG_TRAVEL) ? RATE_W'(25'h100_0000) : RATE_W'($urandom());
        default: v = (i == REG_TRAVEL) ? RATE_W'($urandom_range(0, 200000))
                                       : RATE_W'($urandom_range(0, 32'h3FF_FFFF));
      endcase
      write_reg(cfg_reg_e'(i), v);
    end
  endtask

  task automatic queue_run(input int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 19);
      if (k == 0) pending_beats.push_back(make_beat(1'b0, $urandom_range(0, 3)));
      else if (k < 3) pending_beats.push_back(make_beat(1'b0, 3));
      else if (k < 6) pending_beats.push_back(make_beat(1'b0, 2));
      else pending_beats.push_back(make_beat(1'b1, 3));
    end
  endtask

  initial begin
    seir_beat_t b;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    {in_ch.start_susceptible_a, in_ch.start_exposed_a, in_ch.start_infected_a,
     in_ch.start_recovered_a, in_ch.start_susceptible_b, in_ch.start_exposed_b,
     in_ch.start_infected_b, in_ch.start_recovered_b} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INFECT_A;
    cfg_ch.data = '0;
    rate_reg = '{RST_INFECT_A, RST_INFECT_B, RST_ONSET, RST_ONSET, RST_RECOVER,
                 RST_RECOVER, RATE_W'(RST_TRAVEL)};
    pop_cnt = '{default: 0};
    city_pop = '{default: 0};
    day_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_beats.push_back(make_beat(1'b1, 0));
    pending_beats.push_back(make_beat(1'b0, 0));
    pending_beats.push_back(make_beat(1'b1, 0));
    pending_beats.push_back(make_beat(1'b0, 1));
    for (int i = 0; i < 4; i++) pending_beats.push_back(make_beat(1'b1, 0));
    b = make_beat(1'b0, 2);
    b.ia = '0; b.ib = '0;
    pending_beats.push_back(b);
    pending_beats.push_back(make_beat(1'b1, 0));
    b = make_beat(1'b0, 0);
    b.ia = IN_W'(4096);
    pending_beats.push_back(b);
    pending_beats.push_back(make_beat(1'b1, 0));
    pending_beats.push_back(make_beat(1'b0, 2));
    for (int i = 0; i < 4; i++) pending_beats.push_back(make_beat(1'b1, 0));
    wait_drained();

    hold_sender = 1'b1;
    pending_beats.push_back(make_beat(1'b0, 3));
    pending_beats.push_back(make_beat(1'b1, 0));
    hold_sender = 1'b0;
    wait_drained();

    for (int s = 0; s < 4; s++) begin
      config_phase(s);
      pending_beats.push_back(make_beat(1'b0, 1));
      pending_beats.push_back(make_beat(1'b1, 0));
      pending_beats.push_back(make_beat(1'b1, 0));
      queue_run(s == 3 ? 200 : 120);
      wait_drained();
    end
    write_reg(REG_INFECT_A, RST_INFECT_A);
    write_reg(REG_TRAVEL, RATE_W'(RST_TRAVEL));
    queue_run(260);
    wait_drained();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
